// ===== sv/fat_pkg.sv =====
// ----------------------------------------------------------------------------
// fat_pkg
// Shared types and codes for the chain table engine: word layouts, command
// modes, status codes and the table entry codes.
// ----------------------------------------------------------------------------
package fat_pkg;

    localparam int BLK_W = 10;
    localparam int OFF_W = 22;
    localparam int TOT_W = 11;
    localparam int TOTAL_RESET = 1024;

    localparam logic [1:0] MODE_FORMAT  = 2'd0;
    localparam logic [1:0] MODE_SEEK    = 2'd1;
    localparam logic [1:0] MODE_EXTEND  = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EARLY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADLINK = 2'd3;

    localparam int unsigned CODE_FREE = 0;
    localparam int unsigned CODE_END  = 1;
    localparam int unsigned CODE_BUSY = 2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [BLK_W-1:0] start_block;
        logic [OFF_W-1:0] byte_offset;
    } t_in_word;

    typedef struct packed {
        logic [BLK_W-1:0] result_block;
        logic [1:0]       status;
    } t_out_word;

endpackage

// ===== sv/fat_ram.sv =====
// ----------------------------------------------------------------------------
// fat_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fat_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fat_chain_table_engine.sv =====
// ----------------------------------------------------------------------------
// fat_chain_table_engine
// Block allocation table engine: format, seek, extend and release of block
// chains held in one table RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / i_in_word / o_in_stall) takes one command word
//   at a time; output channel (o_out_valid / o_out_word / i_out_stall) returns
//   exactly one result word per command. i_cfg_we / i_cfg_wdata writes
//   total_blocks; write it only while the engine is idle.
//   Work per command, on the table RAM's one write port and one read port:
//     format  : one entry written per cycle, over all MAX_BLOCKS entries
//     seek    : one link followed per cycle
//     release : one entry read and freed per cycle
//     extend  : free-entry scan reads one entry per cycle
//   A command is accepted only while no other command is in progress; a
//   finished result sits in the output register, so the next command can be
//   taken while the receiver stalls. A further result waits internally.
//   Reset: the table is rebuilt by a sweep over all MAX_BLOCKS entries (formatted
//   image for total_blocks = 1024); o_in_stall stays high during that sweep.
// ----------------------------------------------------------------------------
module fat_chain_table_engine
    import fat_pkg::*;
#(
    parameter int MAX_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_word         i_in_word,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_word        o_out_word,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    input  logic [TOT_W-1:0] i_cfg_wdata
);

    localparam int AW     = $clog2(MAX_BLOCKS);
    localparam int NW     = (AW + 1 > TOT_W) ? AW + 1 : TOT_W;
    localparam int ACC_W  = AW + $clog2(BLOCK_BYTES) + 1;
    localparam int RST_N  = (TOTAL_RESET < MAX_BLOCKS) ? TOTAL_RESET : MAX_BLOCKS;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_FMT, S_SEEK, S_REL, S_SCAN, S_LINK, S_DONE
    } t_state;

    t_state            r_state;
    logic [TOT_W-1:0]  r_total;
    logic [NW-1:0]     r_idx;
    logic [ACC_W-1:0]  r_acc;
    logic [AW-1:0]     r_cur;
    logic [BLK_W-1:0]  r_start;
    logic [OFF_W-1:0]  r_rem;
    logic [AW-1:0]     r_res;
    logic [1:0]        r_stat;
    logic              r_out_valid;
    t_out_word         r_out_word;
    logic              r_byp;
    logic [AW-1:0]     r_byp_data;

    logic              accept;
    logic [NW-1:0]     n_cfg;
    logic [NW-1:0]     n_eff;
    logic [NW+1:0]     four_n;
    logic              fmt_busy;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [AW-1:0]     ram_rdata;
    logic [AW-1:0]     rd_data;
    logic [NW-1:0]     start_n;

    function automatic logic no_chain(input logic [AW-1:0] b);
        return (b == AW'(CODE_FREE)) || (b == AW'(CODE_END));
    endfunction

    fat_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (ram_rdata)
    );

    // same-entry write in the read cycle wins
    assign rd_data = r_byp ? r_byp_data : ram_rdata;

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign n_cfg   = (NW'(r_total) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(r_total);
    assign n_eff   = (r_state == S_INIT) ? NW'(RST_N) : n_cfg;
    assign four_n  = {n_eff, 2'b00};
    assign start_n = NW'(i_in_word.start_block);
    // reserved while i < n and (i < 2 or (i-2)*BLOCK_BYTES < 4n), i.e. inside ceil(4n/B)
    assign fmt_busy = (r_idx < n_eff) &&
                      ((r_idx < NW'(2)) || (r_acc < ACC_W'(four_n)));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = AW'(CODE_FREE);
        mem_raddr = rd_data;
        case (r_state)
            S_INIT, S_FMT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = fmt_busy ? AW'(CODE_BUSY) : AW'(CODE_FREE);
            end
            S_IDLE: begin
                if (i_in_word.mode == MODE_EXTEND) begin
                    mem_raddr = AW'(2);
                end else begin
                    mem_raddr = AW'(i_in_word.start_block);
                end
            end
            S_SEEK: begin
                mem_raddr = rd_data;
            end
            S_REL: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = AW'(CODE_FREE);
                mem_raddr = rd_data;
            end
            S_SCAN: begin
                mem_we    = (rd_data == AW'(CODE_FREE));
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = AW'(CODE_END);
                mem_raddr = AW'(r_idx + NW'(1));
            end
            S_LINK: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_start);
                mem_wdata = r_cur;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_total     <= TOT_W'(TOTAL_RESET);
            r_idx       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_byp      <= mem_we && (mem_waddr == mem_raddr);
            r_byp_data <= mem_wdata;

            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            // the done step reloads the output word itself
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_INIT, S_FMT: begin
                    r_idx <= r_idx + NW'(1);
                    if (r_idx >= NW'(2)) begin
                        r_acc <= r_acc + ACC_W'(BLOCK_BYTES);
                    end
                    if (r_idx == NW'(MAX_BLOCKS - 1)) begin
                        if (r_state == S_INIT) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_res   <= '0;
                            r_stat  <= ST_OK;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_start <= i_in_word.start_block;
                        case (i_in_word.mode)
                            MODE_FORMAT: begin
                                r_idx   <= '0;
                                r_acc   <= '0;
                                r_state <= S_FMT;
                            end
                            MODE_SEEK: begin
                                if (no_chain(AW'(i_in_word.start_block)) &&
                                    (start_n < NW'(2))) begin
                                    r_res   <= '0;
                                    r_stat  <= ST_EARLY;
                                    r_state <= S_DONE;
                                end else if (start_n >= n_eff) begin
                                    r_res   <= '0;
                                    r_stat  <= ST_BADLINK;
                                    r_state <= S_DONE;
                                end else if (i_in_word.byte_offset < OFF_W'(BLOCK_BYTES)) begin
                                    r_res   <= AW'(i_in_word.start_block);
                                    r_stat  <= ST_OK;
                                    r_state <= S_DONE;
                                end else begin
                                    r_res   <= '0;
                                    r_stat  <= ST_OK;
                                    r_cur   <= AW'(i_in_word.start_block);
                                    r_rem   <= i_in_word.byte_offset - OFF_W'(BLOCK_BYTES);
                                    r_state <= S_SEEK;
                                end
                            end
                            MODE_EXTEND: begin
                                r_res <= '0;
                                if ((start_n >= NW'(2)) && (start_n >= n_eff)) begin
                                    r_stat  <= ST_BADLINK;
                                    r_state <= S_DONE;
                                end else if (n_eff <= NW'(2)) begin
                                    r_stat  <= ST_FULL;
                                    r_state <= S_DONE;
                                end else begin
                                    r_stat  <= ST_OK;
                                    r_idx   <= NW'(2);
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_res <= '0;
                                if (start_n < NW'(2)) begin
                                    r_stat  <= ST_OK;
                                    r_state <= S_DONE;
                                end else if (start_n >= n_eff) begin
                                    r_stat  <= ST_BADLINK;
                                    r_state <= S_DONE;
                                end else begin
                                    r_stat  <= ST_OK;
                                    r_cur   <= AW'(i_in_word.start_block);
                                    r_state <= S_REL;
                                end
                            end
                        endcase
                    end
                end
                S_SEEK: begin
                    if (no_chain(rd_data)) begin
                        r_stat  <= ST_EARLY;
                        r_state <= S_DONE;
                    end else if (NW'(rd_data) >= n_eff) begin
                        r_stat  <= ST_BADLINK;
                        r_state <= S_DONE;
                    end else if (r_rem < OFF_W'(BLOCK_BYTES)) begin
                        r_res   <= rd_data;
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= rd_data;
                        r_rem <= r_rem - OFF_W'(BLOCK_BYTES);
                    end
                end
                S_REL: begin
                    if (no_chain(rd_data)) begin
                        r_state <= S_DONE;
                    end else if (NW'(rd_data) >= n_eff) begin
                        r_stat  <= ST_BADLINK;
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= rd_data;
                    end
                end
                S_SCAN: begin
                    if (rd_data == AW'(CODE_FREE)) begin
                        r_cur <= r_idx[AW-1:0];
                        r_res <= r_idx[AW-1:0];
                        if (NW'(r_start) < NW'(2)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LINK;
                        end
                    end else if ((r_idx + NW'(1)) >= n_eff) begin
                        r_stat  <= ST_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_LINK: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid             <= 1'b1;
                        r_out_word.result_block <= BLK_W'(r_res);
                        r_out_word.status       <= r_stat;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("engine took a word but did not go busy");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word appeared outside the done step");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_idx >= NW'(2)) && (r_idx < n_eff)))
        else $error("free-entry scan left the managed range");

    a_rel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL || r_state == S_SEEK) |-> (NW'(r_cur) < n_eff))
        else $error("chain walk holds a block beyond the managed range");

endmodule

// ===== tb/fat_chain_table_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_table_engine_test
// Self-checking bench for the chain table engine. A behavioral copy of the
// allocation table predicts each result word. Directed commands cover the boot
// image, chain build/seek/release, looping chains and tiny or oversized disks.
// Random phases then run file-like traffic under varied sender/receiver idling.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_test
    import fat_pkg::*;
();

    localparam int MAX_BLOCKS   = 1024;
    localparam int BLOCK_BYTES  = 4096;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 1100;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    t_in_word         i_in_word = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_word        o_out_word;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [TOT_W-1:0] i_cfg_wdata = '0;

    // behavioral table and its register
    bit [BLK_W-1:0] fat_img [MAX_BLOCKS];
    int unsigned    disk_blocks;

    t_out_word pending_results [$];
    int        file_head [$];
    int        file_tail [$];
    int        file_len [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int mode_count [4];
    int status_count [4];

    fat_chain_table_engine #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL fat_chain_table_engine");
            $finish;
        end
    end

    // receiver: random stall, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= hold_len;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, o_out_word);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.result_block !== want.result_block) begin
                    $display("%0t: result_block expected %0d actual %0d",
                             $time, want.result_block, o_out_word.result_block);
                    mismatches++;
                end
                if (o_out_word.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out_word.status);
                    mismatches++;
                end
            end
        end
    end

    function automatic int unsigned live_blocks();
        return (disk_blocks > MAX_BLOCKS) ? MAX_BLOCKS : disk_blocks;
    endfunction

    // entry codes 0 and 1 double as "no chain" block numbers
    function automatic bit no_link(int unsigned blk);
        return blk == CODE_FREE || blk == CODE_END;
    endfunction

    function automatic void format_image();
        int unsigned n;
        int unsigned tbl;
        n = live_blocks();
        tbl = (n * 4 + BLOCK_BYTES - 1) / BLOCK_BYTES;
        foreach (fat_img[i]) fat_img[i] = BLK_W'(CODE_FREE);
        for (int unsigned i = 0; i < 2 + tbl; i++)
            if (i < n) fat_img[i] = BLK_W'(CODE_BUSY);
    endfunction

    function automatic t_out_word run_fat_command(t_in_word w);
        int unsigned n;
        int unsigned cur;
        int unsigned nxt;
        int unsigned hops;
        int unsigned i;
        logic [1:0]  st;
        int unsigned blk;
        bit          found;
        t_out_word   r;
        n = live_blocks();
        cur = 32'(w.start_block);
        st = ST_OK;
        blk = 0;
        case (w.mode)
            MODE_FORMAT: begin
                format_image();
            end
            MODE_SEEK: begin
                hops = 32'(w.byte_offset) / BLOCK_BYTES;
                if (no_link(cur)) begin
                    st = ST_EARLY;
                end else begin
                    for (i = 0; i < hops; i++) begin
                        if (cur >= n) begin
                            st = ST_BADLINK;
                            break;
                        end
                        nxt = 32'(fat_img[cur]);
                        if (no_link(nxt)) begin
                            st = ST_EARLY;
                            break;
                        end
                        cur = nxt;
                    end
                    if (st == ST_OK && cur >= n) st = ST_BADLINK;
                    if (st == ST_OK) blk = cur;
                end
            end
            MODE_EXTEND: begin
                if (!no_link(cur) && cur >= n) begin
                    st = ST_BADLINK;
                end else begin
                    found = 1'b0;
                    for (i = 2; i < n; i++) begin
                        if (fat_img[i] == CODE_FREE) begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (!found) begin
                        st = ST_FULL;
                    end else begin
                        fat_img[i] = BLK_W'(CODE_END);
                        if (!no_link(cur)) fat_img[cur] = i[BLK_W-1:0];
                        blk = i;
                    end
                end
            end
            default: begin
                // a loop ends at the first entry already freed
                while (!no_link(cur)) begin
                    if (cur >= n) begin
                        st = ST_BADLINK;
                        break;
                    end
                    nxt = 32'(fat_img[cur]);
                    fat_img[cur] = BLK_W'(CODE_FREE);
                    cur = nxt;
                end
            end
        endcase
        r.result_block = blk[BLK_W-1:0];
        r.status = st;
        return r;
    endfunction

    function automatic t_in_word make_cmd(logic [1:0] m, int unsigned blk, int unsigned off);
        t_in_word w;
        w.mode = m;
        w.start_block = blk[BLK_W-1:0];
        w.byte_offset = off[OFF_W-1:0];
        return w;
    endfunction

    // valid is left high after acceptance; the next word replaces it, an idle gap or wait_idle drops it
    task automatic issue_command(input t_in_word w, output t_out_word r);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        r = run_fat_command(w);
        pending_results.push_back(r);
        mode_count[w.mode]++;
        status_count[r.status]++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic set_disk_blocks(input int unsigned v);
        wait_idle();
        i_cfg_wdata <= v[TOT_W-1:0];
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        disk_blocks = v & 32'h7FF;
        cfg_writes++;
    endtask

    task automatic test_boot_image();
        t_out_word r;
        issue_command(make_cmd(MODE_SEEK, 0, 0), r);
        issue_command(make_cmd(MODE_SEEK, 1, 4096), r);
        issue_command(make_cmd(MODE_SEEK, 2, 0), r);
        issue_command(make_cmd(MODE_SEEK, 1023, 22'h3FFFFF), r);
    endtask

    task automatic test_chain_ops();
        t_out_word r;
        int a;
        int b;
        int c;
        issue_command(make_cmd(MODE_EXTEND, 0, 0), r);
        a = 32'(r.result_block);
        issue_command(make_cmd(MODE_EXTEND, a, 0), r);
        b = 32'(r.result_block);
        issue_command(make_cmd(MODE_EXTEND, b, 0), r);
        c = 32'(r.result_block);
        issue_command(make_cmd(MODE_SEEK, a, 4095), r);
        issue_command(make_cmd(MODE_SEEK, a, 4096), r);
        issue_command(make_cmd(MODE_SEEK, a, 8192), r);
        issue_command(make_cmd(MODE_SEEK, a, 12288), r);
        issue_command(make_cmd(MODE_RELEASE, a, 0), r);
        // extend a freed block that is itself the lowest free: self loop
        issue_command(make_cmd(MODE_EXTEND, a, 0), r);
        issue_command(make_cmd(MODE_SEEK, a, 22'h3FFFFF), r);
        issue_command(make_cmd(MODE_RELEASE, a, 0), r);
        issue_command(make_cmd(MODE_RELEASE, 0, 0), r);
        issue_command(make_cmd(MODE_EXTEND, 1, 0), r);
        issue_command(make_cmd(MODE_RELEASE, 1, 0), r);
        issue_command(make_cmd(MODE_EXTEND, 1023, 0), r);
        issue_command(make_cmd(MODE_SEEK, 1023, 4096), r);
        issue_command(make_cmd(MODE_RELEASE, 1023, 0), r);
        if (c == b) $display("%0t: note, chain did not grow", $time);
    endtask

    task automatic test_disk_sizes();
        t_out_word r;
        int a;
        set_disk_blocks(3);
        issue_command(make_cmd(MODE_FORMAT, 0, 0), r);
        issue_command(make_cmd(MODE_EXTEND, 0, 0), r);
        issue_command(make_cmd(MODE_SEEK, 5, 0), r);
        issue_command(make_cmd(MODE_RELEASE, 7, 0), r);
        issue_command(make_cmd(MODE_EXTEND, 500, 0), r);
        set_disk_blocks(0);
        issue_command(make_cmd(MODE_FORMAT, 0, 0), r);
        issue_command(make_cmd(MODE_EXTEND, 0, 0), r);
        issue_command(make_cmd(MODE_SEEK, 2, 0), r);
        set_disk_blocks(2047);
        issue_command(make_cmd(MODE_FORMAT, 0, 0), r);
        issue_command(make_cmd(MODE_EXTEND, 0, 0), r);
        a = 32'(r.result_block);
        issue_command(make_cmd(MODE_EXTEND, a, 0), r);
        // shrink without format: the chain now links past the disk end
        set_disk_blocks(a + 1);
        issue_command(make_cmd(MODE_SEEK, a, 4096), r);
        issue_command(make_cmd(MODE_RELEASE, a, 0), r);
        set_disk_blocks(TOTAL_RESET);
    endtask

    task automatic test_backpressure();
        t_out_word r;
        idle_pct = 0;
        stall_pct = 0;
        set_disk_blocks(64);
        issue_command(make_cmd(MODE_FORMAT, 0, 0), r);
        hold_len <= 400;
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 10; i++)
            issue_command(make_cmd(i[0] ? MODE_EXTEND : MODE_SEEK, 0, 0), r);
        wait_idle();
        issue_command(make_cmd(MODE_RELEASE, 3, 0), r);
        issue_command(make_cmd(MODE_EXTEND, 0, 0), r);
    endtask

    task automatic test_random_traffic(input int items, input int idle, input int stall,
                                       input int unsigned blocks);
        t_in_word  w;
        t_out_word r;
        int        pick;
        int        k;
        int        hops;
        bit        new_file;
        idle_pct = idle;
        stall_pct = stall;
        set_disk_blocks(blocks);
        file_head.delete();
        file_tail.delete();
        file_len.delete();
        issue_command(make_cmd(MODE_FORMAT, 0, 0), r);
        repeat (items) begin
            pick = $urandom_range(99);
            k = -1;
            new_file = 1'b0;
            if (pick < 34) begin
                if (file_head.size() > 0 && $urandom_range(9) < 6) begin
                    k = $urandom_range(file_head.size() - 1);
                    w = make_cmd(MODE_EXTEND, file_tail[k], 0);
                end else if (file_head.size() < 16 && $urandom_range(3) != 0) begin
                    new_file = 1'b1;
                    w = make_cmd(MODE_EXTEND, 0, 0);
                end else begin
                    w = make_cmd(MODE_EXTEND, $urandom, $urandom);
                end
            end else if (pick < 60) begin
                if (file_head.size() > 0 && $urandom_range(4) != 0) begin
                    k = $urandom_range(file_head.size() - 1);
                    hops = $urandom_range(file_len[k]);
                    w = make_cmd(MODE_SEEK, file_head[k],
                                 hops * BLOCK_BYTES + $urandom_range(BLOCK_BYTES - 1));
                end else begin
                    w = make_cmd(MODE_SEEK, $urandom, $urandom);
                end
            end else if (pick < 76) begin
                if (file_head.size() > 0 && $urandom_range(4) != 0) begin
                    k = $urandom_range(file_head.size() - 1);
                    w = make_cmd(MODE_RELEASE, file_head[k], $urandom);
                end else begin
                    w = make_cmd(MODE_RELEASE, $urandom, $urandom);
                end
            end else if (pick < 79) begin
                w = make_cmd(MODE_FORMAT, $urandom, $urandom);
            end else begin
                w = make_cmd(2'($urandom_range(3)), $urandom, $urandom);
            end
            issue_command(w, r);
            if (w.mode == MODE_FORMAT) begin
                file_head.delete();
                file_tail.delete();
                file_len.delete();
            end else if (pick < 34 && r.status == ST_OK) begin
                if (k >= 0) begin
                    file_tail[k] = 32'(r.result_block);
                    file_len[k]++;
                end else if (new_file) begin
                    file_head.push_back(32'(r.result_block));
                    file_tail.push_back(32'(r.result_block));
                    file_len.push_back(1);
                end
            end else if (pick >= 60 && pick < 76 && k >= 0) begin
                file_head.delete(k);
                file_tail.delete(k);
                file_len.delete(k);
            end
        end
    endtask

    initial begin
        disk_blocks = TOTAL_RESET;
        format_image();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_boot_image();
        test_chain_ops();
        test_disk_sizes();
        test_backpressure();
        test_random_traffic(120, 0, 0, 1024);
        test_random_traffic(120, 73, 0, 40);
        test_random_traffic(120, 0, 73, $urandom_range(3, 200));
        test_random_traffic(110, 23, 23, 2047);
        test_random_traffic(60, 0, 0, 8);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d commands (format %0d, seek %0d, extend %0d, release %0d)",
                 mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
                 mode_count[MODE_FORMAT], mode_count[MODE_SEEK], mode_count[MODE_EXTEND],
                 mode_count[MODE_RELEASE]);
        $display("over %0d disk sizes; checked %0d words: ok %0d, short chain %0d,",
                 cfg_writes, results_checked, status_count[ST_OK], status_count[ST_EARLY]);
        $display("disk full %0d, bad link %0d; %0d mismatches",
                 status_count[ST_FULL], status_count[ST_BADLINK], mismatches);
        if (mismatches == 0) begin
            $display("PASS fat_chain_table_engine");
        end else begin
            $display("FAIL fat_chain_table_engine");
        end
        $finish;
    end

endmodule

// ===== fat_chain_table_engine.f =====
sv/fat_pkg.sv
sv/fat_ram.sv
sv/fat_chain_table_engine.sv
tb/fat_chain_table_engine_test.sv
